### hw/rtl/hsr_pkg.sv
// Package with shared types and constants of the hue/saturation to RGB converter.
package hsr_pkg;

   // Payload field types
   typedef logic signed [15:0] hue_type;
   typedef logic [12:0]        sat_type;
   typedef logic [13:0]        bri_type;
   typedef logic [5:0]         chan_type;

   // Channel level over the denominator 4096*3840 (fits in 24 bits)
   typedef logic [23:0] level_type;

   // Hue sextant: which pair of channels carries chroma and the ramp
   typedef enum logic [2:0] {
      SEXT_RED_YELLOW    = 3'd0,
      SEXT_YELLOW_GREEN  = 3'd1,
      SEXT_GREEN_CYAN    = 3'd2,
      SEXT_CYAN_BLUE     = 3'd3,
      SEXT_BLUE_MAGENTA  = 3'd4,
      SEXT_MAGENTA_RED   = 3'd5
   } sextant_type;

   // Hue geometry in 1/64 degree units
   localparam logic signed [16:0] HUE_TURN = 17'sd23040;
   localparam logic [14:0]        SEXTANT  = 15'd3840;

   // Saturation full scale (Q12)
   localparam logic [12:0] SAT_ONE = 13'd4096;

   // Brightness clamp limits in hundredths of a percent
   localparam logic [13:0] BRI_MIN = 14'd10;
   localparam logic [13:0] BRI_MAX = 14'd2000;

   // Peak = floor((51*b + 1000) / 2000) = floor((that >> 4) / 125)
   localparam logic [16:0] PEAK_BIAS  = 17'd1000;
   localparam logic [13:0] PEAK_RECIP = 14'd8389;   // ceil(2^20 / 125)
   localparam int          PEAK_SHIFT = 20;

   // Full channel level and its rounding half: 15 * 2^20
   localparam level_type   LEVEL_FULL = 24'd15728640;
   localparam logic [29:0] LEVEL_HALF = 30'd7864320;

   // Final divide by 15 after the shift by 20
   localparam logic [10:0] DIV15_RECIP = 11'd1093;  // ceil(2^14 / 15)
   localparam int          DIV15_SHIFT = 14;

endpackage

### hw/rtl/hsr_req_if.sv
// Request channel: one LED style per transaction.
interface hsr_req_if import hsr_pkg::*; ();
   logic    valid;
   logic    ready;
   hue_type hue;
   sat_type saturation;
   bri_type brightness;

   modport source (output valid, output hue, output saturation, output brightness,
                   input ready);
   modport sink   (input valid, input hue, input saturation, input brightness,
                   output ready);
endinterface

### hw/rtl/hsr_rsp_if.sv
// Response channel: one RGB triple per transaction.
interface hsr_rsp_if import hsr_pkg::*; ();
   logic     valid;
   logic     ready;
   chan_type red;
   chan_type green;
   chan_type blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

### hw/rtl/hue_saturation_to_rgb.sv
// Top level: six-stage pipeline converting hue/saturation/brightness into RGB.
//
//   channel    direction  payload                               per transaction
//   req_chan   in         hue s16, saturation u13, brightness   one LED style
//   rsp_chan   out        red, green, blue (u6 each, 0..51)     one RGB triple
//
// One transaction enters per cycle while the response side is ready; each result
// passes through the six register stages in turn:
// wrap and clamp, sextant split and peak multiply, ramp multiply, peak scaling,
// rounding, and the divide by 15. Reset clears only the stage valid bits.
// Each stage holds while the stage after it is full and stalled, so bubbles
// close up and a stall neither drops nor repeats a transaction.
module hue_saturation_to_rgb import hsr_pkg::*; (
   input logic     clock,
   input logic     reset,
   hsr_req_if.sink   req_chan,
   hsr_rsp_if.source rsp_chan
);

   // Stage valid bits and per-stage load enables
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic en1, en2, en3, en4, en5, en6;

   // Stage 1 registers
   logic [14:0] h1_ff, h1_in;
   sat_type     s1_ff, s1_in;
   logic [12:0] z1_ff, z1_in;

   // Stage 2 registers
   sextant_type sect2_ff, sect2_in;
   logic [11:0] t2_ff, t2_in;
   sat_type     s2_ff;
   logic [26:0] zq2_ff, zq2_in;

   // Stage 3 registers
   level_type   lr3_ff, lg3_ff, lb3_ff;
   level_type   lr3_in, lg3_in, lb3_in;
   logic [5:0]  peak3_ff, peak3_in;

   // Stage 4 registers
   logic [29:0] pr4_ff, pg4_ff, pb4_ff;

   // Stage 5 registers
   logic [9:0]  wr5_ff, wg5_ff, wb5_ff;
   logic [29:0] sr5, sg5, sb5;

   // Stage 6 registers (output)
   chan_type    red6_ff, green6_ff, blue6_ff;
   logic [20:0] qr6, qg6, qb6;

   // Stage 1 helpers
   logic signed [16:0] hue_ext;
   logic signed [16:0] hue_wrap;
   bri_type            bri_clamp;
   logic [16:0]        peak_num;

   // Stage 2 helpers
   logic [14:0] rem2;

   // Stage 3 helpers
   level_type  ramp3, white3, mid3;
   logic [5:0] peak_raw;

   // Ready chain: a stage loads when it is empty or the next one moves
   assign en6 = !v6_ff || rsp_chan.ready;
   assign en5 = !v5_ff || en6;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_chan.ready = en1;

   // Advance the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_chan.valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
         if (en6) v6_ff <= v5_ff;
      end
   end

   // Stage 1: wrap hue into one turn, clamp saturation and brightness, form the peak numerator
   always_comb begin
      hue_ext = {req_chan.hue[15], req_chan.hue};
      if (hue_ext < -HUE_TURN) begin
         hue_wrap = hue_ext + HUE_TURN + HUE_TURN;
      end else if (hue_ext < 17'sd0) begin
         hue_wrap = hue_ext + HUE_TURN;
      end else if (hue_ext >= HUE_TURN) begin
         hue_wrap = hue_ext - HUE_TURN;
      end else begin
         hue_wrap = hue_ext;
      end
      h1_in = hue_wrap[14:0];

      s1_in = (req_chan.saturation > SAT_ONE) ? SAT_ONE : req_chan.saturation;

      if (req_chan.brightness < BRI_MIN) begin
         bri_clamp = BRI_MIN;
      end else if (req_chan.brightness > BRI_MAX) begin
         bri_clamp = BRI_MAX;
      end else begin
         bri_clamp = req_chan.brightness;
      end
      peak_num = 17'(bri_clamp) * 17'd51 + PEAK_BIAS;
      z1_in    = peak_num[16:4];
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         h1_ff <= h1_in;
         s1_ff <= s1_in;
         z1_ff <= z1_in;
      end
   end

   // Stage 2: split hue into sextant and ramp distance, start the peak divide
   always_comb begin
      if (h1_ff >= 15'(SEXTANT * 15'd5)) begin
         sect2_in = SEXT_MAGENTA_RED;
         rem2     = h1_ff - 15'(SEXTANT * 15'd5);
      end else if (h1_ff >= 15'(SEXTANT * 15'd4)) begin
         sect2_in = SEXT_BLUE_MAGENTA;
         rem2     = h1_ff - 15'(SEXTANT * 15'd4);
      end else if (h1_ff >= 15'(SEXTANT * 15'd3)) begin
         sect2_in = SEXT_CYAN_BLUE;
         rem2     = h1_ff - 15'(SEXTANT * 15'd3);
      end else if (h1_ff >= 15'(SEXTANT * 15'd2)) begin
         sect2_in = SEXT_GREEN_CYAN;
         rem2     = h1_ff - 15'(SEXTANT * 15'd2);
      end else if (h1_ff >= SEXTANT) begin
         sect2_in = SEXT_YELLOW_GREEN;
         rem2     = h1_ff - SEXTANT;
      end else begin
         sect2_in = SEXT_RED_YELLOW;
         rem2     = h1_ff;
      end
      // Odd sextants ramp down toward the next primary
      t2_in  = sect2_in[0] ? 12'(SEXTANT - rem2) : rem2[11:0];
      zq2_in = 27'(z1_ff) * 27'(PEAK_RECIP);
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         sect2_ff <= sect2_in;
         t2_ff    <= t2_in;
         s2_ff    <= s1_ff;
         zq2_ff   <= zq2_in;
      end
   end

   // Stage 3: build channel levels (chroma + white is always full scale)
   always_comb begin
      ramp3  = 24'(s2_ff) * 24'(t2_ff);
      white3 = 24'(SAT_ONE - s2_ff) * 24'(SEXTANT);
      mid3   = ramp3 + white3;

      peak_raw = zq2_ff[PEAK_SHIFT +: 6];
      peak3_in = (peak_raw == 6'd0) ? 6'd1 : peak_raw;

      case (sect2_ff)
         SEXT_RED_YELLOW: begin
            lr3_in = LEVEL_FULL; lg3_in = mid3;       lb3_in = white3;
         end
         SEXT_YELLOW_GREEN: begin
            lr3_in = mid3;       lg3_in = LEVEL_FULL; lb3_in = white3;
         end
         SEXT_GREEN_CYAN: begin
            lr3_in = white3;     lg3_in = LEVEL_FULL; lb3_in = mid3;
         end
         SEXT_CYAN_BLUE: begin
            lr3_in = white3;     lg3_in = mid3;       lb3_in = LEVEL_FULL;
         end
         SEXT_BLUE_MAGENTA: begin
            lr3_in = mid3;       lg3_in = white3;     lb3_in = LEVEL_FULL;
         end
         default: begin
            lr3_in = LEVEL_FULL; lg3_in = white3;     lb3_in = mid3;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         lr3_ff   <= lr3_in;
         lg3_ff   <= lg3_in;
         lb3_ff   <= lb3_in;
         peak3_ff <= peak3_in;
      end
   end

   // Stage 4: scale each level by the peak
   always_ff @(posedge clock) begin
      if (en4) begin
         pr4_ff <= 30'(lr3_ff) * 30'(peak3_ff);
         pg4_ff <= 30'(lg3_ff) * 30'(peak3_ff);
         pb4_ff <= 30'(lb3_ff) * 30'(peak3_ff);
      end
   end

   // Stage 5: add the rounding half and drop the power-of-two part of the divisor
   assign sr5 = pr4_ff + LEVEL_HALF;
   assign sg5 = pg4_ff + LEVEL_HALF;
   assign sb5 = pb4_ff + LEVEL_HALF;

   always_ff @(posedge clock) begin
      if (en5) begin
         wr5_ff <= sr5[29:20];
         wg5_ff <= sg5[29:20];
         wb5_ff <= sb5[29:20];
      end
   end

   // Stage 6: divide by 15 through the reciprocal and hold the result
   assign qr6 = 21'(wr5_ff) * 21'(DIV15_RECIP);
   assign qg6 = 21'(wg5_ff) * 21'(DIV15_RECIP);
   assign qb6 = 21'(wb5_ff) * 21'(DIV15_RECIP);

   always_ff @(posedge clock) begin
      if (en6) begin
         red6_ff   <= qr6[DIV15_SHIFT +: 6];
         green6_ff <= qg6[DIV15_SHIFT +: 6];
         blue6_ff  <= qb6[DIV15_SHIFT +: 6];
      end
   end

   // Drive the response channel
   assign rsp_chan.valid = v6_ff;
   assign rsp_chan.red   = red6_ff;
   assign rsp_chan.green = green6_ff;
   assign rsp_chan.blue  = blue6_ff;

endmodule
